// ----- hw/rtl/ifsf_pkg.sv -----
package ifsf_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_FLAG_BYTE         = 3'd0;
    localparam logic [2:0] REG_ADDRESS_BYTE      = 3'd1;
    localparam logic [2:0] REG_ESCAPE_BYTE       = 3'd2;
    localparam logic [2:0] REG_FLAG_SUBSTITUTE   = 3'd3;
    localparam logic [2:0] REG_ESCAPE_SUBSTITUTE = 3'd4;
    localparam logic [2:0] REG_CONTROL_SEQ_ZERO  = 3'd5;
    localparam logic [2:0] REG_CONTROL_SEQ_ONE   = 3'd6;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_FLAG_BYTE         = 8'd126;
    localparam logic [7:0] RST_ADDRESS_BYTE      = 8'd3;
    localparam logic [7:0] RST_ESCAPE_BYTE       = 8'd125;
    localparam logic [7:0] RST_FLAG_SUBSTITUTE   = 8'd94;
    localparam logic [7:0] RST_ESCAPE_SUBSTITUTE = 8'd93;
    localparam logic [7:0] RST_CONTROL_SEQ_ZERO  = 8'd0;
    localparam logic [7:0] RST_CONTROL_SEQ_ONE   = 8'd64;

    // Input item opcodes
    localparam logic OP_PAYLOAD = 1'b0;
    localparam logic OP_ACK     = 1'b1;

    // Depth of the command queue between front and back (at least 2)
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] address_byte;
        logic [7:0] escape_byte;
        logic [7:0] flag_substitute;
        logic [7:0] escape_substitute;
        logic [7:0] control_seq_zero;
        logic [7:0] control_seq_one;
    } cfg_t;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       ack_seq;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } out_t;

    // One payload byte, classified by the front
    typedef struct packed {
        logic       hdr;       // header goes out first
        logic [7:0] ctrl;      // control byte for the header
        logic [7:0] data;      // payload byte
        logic       last;      // check and closing flag follow
        logic [7:0] check;     // frame check after this byte
    } cmd_t;

endpackage

// ----- hw/rtl/ifsf_front.sv -----
module ifsf_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  ifsf_pkg::cfg_t      cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  ifsf_pkg::in_t       s_data,
    input  logic                q_full,
    output logic                q_push,
    output ifsf_pkg::cmd_t      q_cmd
);

    logic       seq_bit_reg, seq_bit_next;
    logic       in_frame_reg, in_frame_next;
    logic [7:0] check_reg, check_next;

    logic       accept;
    logic       open_frame;
    logic [7:0] check_base;
    logic [7:0] check_new;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Classify the item and build the command for the back end
    always_comb begin
        open_frame = s_data.first_byte || !in_frame_reg;
        check_base = open_frame ? 8'd0 : check_reg;
        check_new  = check_base ^ s_data.data_byte;

        q_push      = accept && (s_data.op == ifsf_pkg::OP_PAYLOAD);
        q_cmd.hdr   = open_frame;
        q_cmd.ctrl  = seq_bit_reg ? cfg.control_seq_one : cfg.control_seq_zero;
        q_cmd.data  = s_data.data_byte;
        q_cmd.last  = s_data.last_byte;
        q_cmd.check = check_new;
    end

    // Frame state update
    always_comb begin
        seq_bit_next  = seq_bit_reg;
        in_frame_next = in_frame_reg;
        check_next    = check_reg;
        if (accept) begin
            if (s_data.op == ifsf_pkg::OP_ACK) begin
                seq_bit_next = s_data.ack_seq;
            end else begin
                in_frame_next = !s_data.last_byte;
                check_next    = s_data.last_byte ? 8'd0 : check_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_bit_reg  <= 1'b0;
            in_frame_reg <= 1'b0;
            check_reg    <= 8'd0;
        end else begin
            seq_bit_reg  <= seq_bit_next;
            in_frame_reg <= in_frame_next;
            check_reg    <= check_next;
        end
    end

endmodule

// ----- hw/rtl/ifsf_queue.sv -----
module ifsf_queue #(
    parameter int Depth = ifsf_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ifsf_pkg::cmd_t      push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output ifsf_pkg::cmd_t      pop_cmd
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    ifsf_pkg::cmd_t    entry_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CntW'(Depth));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hw/rtl/ifsf_back.sv -----
module ifsf_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  ifsf_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  ifsf_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output ifsf_pkg::out_t      m_data
);

    // Byte sequencer steps
    localparam logic [3:0] ST_FLAG  = 4'd0;
    localparam logic [3:0] ST_ADDR  = 4'd1;
    localparam logic [3:0] ST_CTRL  = 4'd2;
    localparam logic [3:0] ST_HCS   = 4'd3;
    localparam logic [3:0] ST_DATA  = 4'd4;
    localparam logic [3:0] ST_DSUB  = 4'd5;
    localparam logic [3:0] ST_CHK   = 4'd6;
    localparam logic [3:0] ST_CSUB  = 4'd7;
    localparam logic [3:0] ST_EFLAG = 4'd8;

    logic               busy_reg, busy_next;
    ifsf_pkg::cmd_t     cmd_reg, cmd_next;
    logic [3:0]         step_reg, step_next;
    logic               m_valid_reg, m_valid_next;
    ifsf_pkg::out_t     m_data_reg, m_data_next;

    logic               emit;
    logic               fin;
    logic               frame_end;
    logic [3:0]         step_after;
    logic [7:0]         byte_out;
    logic               data_flag, data_esc, chk_flag, chk_esc;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign emit    = busy_reg && (!m_valid_reg || m_ready);
    assign q_pop   = q_valid && (!busy_reg || (emit && fin));

    // Stuffing matches; a byte equal to both flag and escape counts as flag
    always_comb begin
        data_flag = (cmd_reg.data == cfg.flag_byte);
        data_esc  = data_flag || (cmd_reg.data == cfg.escape_byte);
        chk_flag  = (cmd_reg.check == cfg.flag_byte);
        chk_esc   = chk_flag || (cmd_reg.check == cfg.escape_byte);
    end

    // Byte for the current step and the step that follows
    always_comb begin
        byte_out   = cfg.flag_byte;
        fin        = 1'b0;
        frame_end  = 1'b0;
        step_after = step_reg;
        unique case (step_reg)
            ST_FLAG: begin
                byte_out   = cfg.flag_byte;
                step_after = ST_ADDR;
            end
            ST_ADDR: begin
                byte_out   = cfg.address_byte;
                step_after = ST_CTRL;
            end
            ST_CTRL: begin
                byte_out   = cmd_reg.ctrl;
                step_after = ST_HCS;
            end
            ST_HCS: begin
                byte_out   = cfg.address_byte ^ cmd_reg.ctrl;
                step_after = ST_DATA;
            end
            ST_DATA: begin
                byte_out   = data_esc ? cfg.escape_byte : cmd_reg.data;
                step_after = data_esc ? ST_DSUB : ST_CHK;
                fin        = !data_esc && !cmd_reg.last;
            end
            ST_DSUB: begin
                byte_out   = data_flag ? cfg.flag_substitute : cfg.escape_substitute;
                step_after = ST_CHK;
                fin        = !cmd_reg.last;
            end
            ST_CHK: begin
                byte_out   = chk_esc ? cfg.escape_byte : cmd_reg.check;
                step_after = chk_esc ? ST_CSUB : ST_EFLAG;
            end
            ST_CSUB: begin
                byte_out   = chk_flag ? cfg.flag_substitute : cfg.escape_substitute;
                step_after = ST_EFLAG;
            end
            ST_EFLAG: begin
                byte_out  = cfg.flag_byte;
                fin       = 1'b1;
                frame_end = 1'b1;
            end
            default: begin
                byte_out = cfg.flag_byte;
                fin      = 1'b1;
            end
        endcase
    end

    // Sequencer and output register
    always_comb begin
        busy_next    = busy_reg;
        cmd_next     = cmd_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next         = 1'b1;
            m_data_next.out_byte = byte_out;
            m_data_next.run_last = fin;
            m_data_next.frame_end = frame_end;
            if (fin) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_after;
            end
        end
        if (q_pop) begin
            busy_next = 1'b1;
            cmd_next  = q_cmd;
            step_next = q_cmd.hdr ? ST_FLAG : ST_DATA;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            step_reg    <= ST_FLAG;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ----- hw/rtl/info_frame_stuffing_framer.sv -----
// Channel   Direction  Handshake           Item
// s_        in         s_valid / s_ready   payload byte or acknowledgement
// m_        out        m_valid / m_ready   one byte of the framed stream
// cfg_      in         cfg_valid/cfg_ready register index and write data
//
// Output runs at one byte per cycle while m_ready is high; a payload byte yields
// 1 to 9 bytes in the back-end byte sequencer (4 header bytes, 1-2 data, 1-2 check,
// closing flag). Acknowledgements are consumed in the front and produce no output.
// The front takes an item per cycle while the command queue has room.
// Reset is synchronous, active low, and restores the configuration reset values.
// A stalled m_ready holds the output register; the queue absorbs input meanwhile.
module info_frame_stuffing_framer #(
    parameter int QueueDepth = ifsf_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ifsf_pkg::in_t       s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ifsf_pkg::out_t      m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    ifsf_pkg::cfg_t cfg_reg, cfg_next;
    logic           q_push, q_full, q_pop, q_valid;
    ifsf_pkg::cmd_t push_cmd, pop_cmd;

    assign cfg_ready = 1'b1;

    // Configuration register file
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                ifsf_pkg::REG_FLAG_BYTE:         cfg_next.flag_byte         = cfg_data;
                ifsf_pkg::REG_ADDRESS_BYTE:      cfg_next.address_byte      = cfg_data;
                ifsf_pkg::REG_ESCAPE_BYTE:       cfg_next.escape_byte       = cfg_data;
                ifsf_pkg::REG_FLAG_SUBSTITUTE:   cfg_next.flag_substitute   = cfg_data;
                ifsf_pkg::REG_ESCAPE_SUBSTITUTE: cfg_next.escape_substitute = cfg_data;
                ifsf_pkg::REG_CONTROL_SEQ_ZERO:  cfg_next.control_seq_zero  = cfg_data;
                ifsf_pkg::REG_CONTROL_SEQ_ONE:   cfg_next.control_seq_one   = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_byte         <= ifsf_pkg::RST_FLAG_BYTE;
            cfg_reg.address_byte      <= ifsf_pkg::RST_ADDRESS_BYTE;
            cfg_reg.escape_byte       <= ifsf_pkg::RST_ESCAPE_BYTE;
            cfg_reg.flag_substitute   <= ifsf_pkg::RST_FLAG_SUBSTITUTE;
            cfg_reg.escape_substitute <= ifsf_pkg::RST_ESCAPE_SUBSTITUTE;
            cfg_reg.control_seq_zero  <= ifsf_pkg::RST_CONTROL_SEQ_ZERO;
            cfg_reg.control_seq_one   <= ifsf_pkg::RST_CONTROL_SEQ_ONE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept and classify
    ifsf_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    // Command queue
    ifsf_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (pop_cmd)
    );

    // Back: byte sequencer and output register
    ifsf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_cmd   (pop_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Closing flag always ends its item's run
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_end |-> m_data.run_last)
        else $error("frame_end without run_last");

    // Closing flag carries the flag value
    a_end_is_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_end |-> m_data.out_byte == cfg_reg.flag_byte)
        else $error("closing byte is not the flag");

    // Acknowledgements never enter the queue
    a_ack_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.op == ifsf_pkg::OP_ACK |-> !q_push)
        else $error("acknowledgement pushed into queue");

    // Queue is pushed only on an accepted item
    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> s_valid && s_ready)
        else $error("queue push without accepted item");

endmodule

// ----- test/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ifsf_pkg::*;

    // Predicts the framed byte stream and checks it against the block
    class framed_stream_model;
        cfg_t       regs;
        logic [7:0] frame_xor;
        logic       seq;
        logic       frame_open;
        out_t       expected_bytes[$];
        int         mismatch_count;

        function new();
            regs.flag_byte         = RST_FLAG_BYTE;
            regs.address_byte      = RST_ADDRESS_BYTE;
            regs.escape_byte       = RST_ESCAPE_BYTE;
            regs.flag_substitute   = RST_FLAG_SUBSTITUTE;
            regs.escape_substitute = RST_ESCAPE_SUBSTITUTE;
            regs.control_seq_zero  = RST_CONTROL_SEQ_ZERO;
            regs.control_seq_one   = RST_CONTROL_SEQ_ONE;
            frame_xor      = 8'h00;
            seq            = 1'b0;
            frame_open     = 1'b0;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                REG_FLAG_BYTE:         regs.flag_byte         = val;
                REG_ADDRESS_BYTE:      regs.address_byte      = val;
                REG_ESCAPE_BYTE:       regs.escape_byte       = val;
                REG_FLAG_SUBSTITUTE:   regs.flag_substitute   = val;
                REG_ESCAPE_SUBSTITUTE: regs.escape_substitute = val;
                REG_CONTROL_SEQ_ZERO:  regs.control_seq_zero  = val;
                REG_CONTROL_SEQ_ONE:   regs.control_seq_one   = val;
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] b, logic closing);
            out_t o;
            o.out_byte  = b;
            o.run_last  = 1'b0;
            o.frame_end = closing;
            expected_bytes.push_back(o);
        endfunction

        // Flag match wins when flag and escape are the same value
        function void push_stuffed(logic [7:0] b);
            if (b == regs.flag_byte) begin
                push_byte(regs.escape_byte, 1'b0);
                push_byte(regs.flag_substitute, 1'b0);
            end else if (b == regs.escape_byte) begin
                push_byte(regs.escape_byte, 1'b0);
                push_byte(regs.escape_substitute, 1'b0);
            end else begin
                push_byte(b, 1'b0);
            end
        endfunction

        // Note an accepted item and queue the bytes it must produce
        function void predict_frame_bytes(in_t item);
            logic [7:0] ctrl;
            out_t       tail;
            if (item.op == OP_ACK) begin
                if (item.ack_seq != seq)
                    seq = ~seq;
                return;
            end
            if (item.first_byte || !frame_open) begin
                ctrl = seq ? regs.control_seq_one : regs.control_seq_zero;
                push_byte(regs.flag_byte, 1'b0);
                push_byte(regs.address_byte, 1'b0);
                push_byte(ctrl, 1'b0);
                push_byte(regs.address_byte ^ ctrl, 1'b0);
                frame_xor  = 8'h00;
                frame_open = 1'b1;
            end
            frame_xor = frame_xor ^ item.data_byte;
            push_stuffed(item.data_byte);
            if (item.last_byte) begin
                push_stuffed(frame_xor);
                push_byte(regs.flag_byte, 1'b1);
                frame_xor  = 8'h00;
                frame_open = 1'b0;
            end
            tail = expected_bytes.pop_back();
            tail.run_last = 1'b1;
            expected_bytes.push_back(tail);
        endfunction

        function void check_byte(out_t got);
            out_t want;
            if (expected_bytes.size() == 0) begin
                $error("unexpected output byte %h", got.out_byte);
                mismatch_count++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
                mismatch_count++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %b, actual %b", want.run_last, got.run_last);
                mismatch_count++;
            end
            if (got.frame_end !== want.frame_end) begin
                $error("frame_end: expected %b, actual %b", want.frame_end, got.frame_end);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_t        s_data;
    logic       m_valid;
    logic       m_ready;
    out_t       m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    framed_stream_model stream_model = new();
    int burst_left;
    bit hold_request;

    info_frame_stuffing_framer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Handshake monitors
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            stream_model.predict_frame_bytes(s_data);
        if (aresetn && m_valid && m_ready)
            stream_model.check_byte(m_data);
        if (aresetn && cfg_valid && cfg_ready)
            stream_model.write_reg(cfg_index, cfg_data);
    end

    function automatic in_t payload_item(logic [7:0] data, logic first, logic last);
        in_t it;
        it.op         = OP_PAYLOAD;
        it.data_byte  = data;
        it.first_byte = first;
        it.last_byte  = last;
        it.ack_seq    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Unused fields of an acknowledgement carry random junk
    function automatic in_t ack_item(logic want_seq);
        in_t it;
        it         = in_t'($urandom);
        it.op      = OP_ACK;
        it.ack_seq = want_seq;
        return it;
    endfunction

    // Payload byte biased toward the flag and escape values
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return stream_model.regs.flag_byte;
            1:       return stream_model.regs.escape_byte;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one item, then maybe drop valid for a random gap
    task automatic offer(input in_t item);
        int gap;
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [7:0] flag, input logic [7:0] addr,
                             input logic [7:0] esc, input logic [7:0] flag_sub,
                             input logic [7:0] esc_sub, input logic [7:0] ctrl0,
                             input logic [7:0] ctrl1);
        write_reg(REG_FLAG_BYTE, flag);
        write_reg(REG_ADDRESS_BYTE, addr);
        write_reg(REG_ESCAPE_BYTE, esc);
        write_reg(REG_FLAG_SUBSTITUTE, flag_sub);
        write_reg(REG_ESCAPE_SUBSTITUTE, esc_sub);
        write_reg(REG_CONTROL_SEQ_ZERO, ctrl0);
        write_reg(REG_CONTROL_SEQ_ONE, ctrl1);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait so the last accepted item is predicted, wait for every
    // expected byte, then idle before returning
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (stream_model.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // Special cases at reset settings (flag 7e, escape 7d)
    task automatic directed_items();
        offer(payload_item(8'h00, 1'b0, 1'b0));   // no frame open yet
        offer(payload_item(8'hff, 1'b0, 1'b0));
        offer(payload_item(8'h7e, 1'b0, 1'b0));   // flag in payload
        offer(payload_item(8'h7d, 1'b0, 1'b0));   // escape in payload
        offer(payload_item(8'h82, 1'b0, 1'b1));   // check comes out as flag
        offer(ack_item(1'b0));                    // same seq, no change
        offer(ack_item(1'b1));                    // toggles seq
        offer(payload_item(8'h7d, 1'b1, 1'b1));   // one-byte frame, nine bytes
        offer(payload_item(8'h11, 1'b1, 1'b0));
        offer(payload_item(8'h22, 1'b1, 1'b0));   // abandons the open frame
        offer(payload_item(8'h5f, 1'b0, 1'b1));   // check comes out as escape
        offer(ack_item(1'b0));
        offer(ack_item(1'b0));
        offer(payload_item(8'haa, 1'b1, 1'b1));
        offer(payload_item(8'h00, 1'b1, 1'b1));
        offer(payload_item(8'hff, 1'b1, 1'b1));
    endtask

    // Mostly well-formed frames, some acks, broken frames and noise
    task automatic random_traffic(input int payload_count);
        int   sent;
        int   len;
        int   pick;
        in_t  junk;
        sent = 0;
        while (sent < payload_count) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    offer(payload_item(pick_byte(), k == 0 || pick == 6,
                                       k == len - 1 && pick != 6));
                sent += len;
            end else if (pick <= 8) begin
                offer(ack_item(1'($urandom_range(0, 1))));
            end else begin
                junk = in_t'($urandom);
                offer(junk);
                if (junk.op == OP_PAYLOAD)
                    sent++;
            end
        end
    endtask

    // Receiver: stall modes of random length, plus one long hold-off on request
    initial begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 200;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(5, 60);
                end
                mode_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    2:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
            @(posedge aclk);
        end
    end

    // Main sequence
    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_FLAG_BYTE;
        cfg_data     = 8'h00;
        burst_left   = 0;
        hold_request = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_items();
        random_traffic(40);
        drain();

        // Extremes; the block is made to back up under a long output stall
        configure(8'h00, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00);
        hold_request = 1'b1;
        random_traffic(50);
        drain();

        // Flag and escape share one value
        configure(8'h55, 8'haa, 8'h55, 8'h01, 8'h02, 8'h80, 8'h7f);
        random_traffic(40);
        drain();

        configure(8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff);
        random_traffic(40);
        drain();

        configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom));
        random_traffic(40);
        drain();

        if (stream_model.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit
    initial begin
        #3_600_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ifsf_pkg.sv
hw/rtl/ifsf_front.sv
hw/rtl/ifsf_queue.sv
hw/rtl/ifsf_back.sv
hw/rtl/info_frame_stuffing_framer.sv
test/tb.sv
